// ===== rtl/ssui_pkg.sv =====
// ssui_pkg: shared types and constants for the sorted set union/intersection block.
// Used by ssui_cell, ssui_list and sorted_set_union_intersection. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ssui_pkg;

   localparam int LIST_DEPTH  = 16;
   localparam int MAX_RESULTS = 48;
   localparam int ELEM_W      = 32;
   localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
   localparam int K_W         = $clog2(MAX_RESULTS + 1);

   localparam logic [1:0] ACT_FIRST   = 2'd0;
   localparam logic [1:0] ACT_SECOND  = 2'd1;
   localparam logic [1:0] ACT_COMPUTE = 2'd2;

   localparam logic SET_UNION = 1'b0;
   localparam logic SET_INTER = 1'b1;

   typedef logic signed [ELEM_W-1:0] elem_type;

   typedef struct packed {
      logic [1:0] action;
      elem_type   value;
   } req_type;

   typedef struct packed {
      logic     set_kind;
      elem_type element;
      logic     empty_res;
      logic     overflow;
      logic     last;
   } rsp_type;

   typedef struct packed {
      logic ins;
      logic shift;
      logic clr;
   } list_cmd_type;

   typedef struct packed {
      logic ins;
      logic shift;
   } cell_cmd_type;

endpackage
`default_nettype wire

// ===== rtl/ssui_cell.sv =====
// ssui_cell: one element slot of a sorted list chain.
// Insert takes own, left neighbor or new value; shift takes the right neighbor. Uses ssui_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ssui_cell (
   input  wire                   clock,
   input  ssui_pkg::cell_cmd_type cmd,
   input  ssui_pkg::elem_type    value_in,
   input  ssui_pkg::elem_type    left_val,
   input  ssui_pkg::elem_type    right_val,
   input  wire                   own_valid,
   input  wire                   left_lt,
   output ssui_pkg::elem_type    val,
   output logic                  lt
);

   ssui_pkg::elem_type val_ff;
   ssui_pkg::elem_type val_in;

   assign val = val_ff;
   assign lt  = own_valid && (val_ff < value_in);

   always_comb begin
      val_in = val_ff;
      if (cmd.ins) begin
         if (!lt) begin
            val_in = left_lt ? value_in : left_val;
         end
      end else if (cmd.shift) begin
         val_in = right_val;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule
`default_nettype wire

// ===== rtl/ssui_list.sv =====
// ssui_list: bounded ascending list as a chain of ssui_cell slots plus a fill count.
// Shift pops the head and rotates it to the tail slot. Uses ssui_pkg, ssui_cell.
`timescale 1ns / 1ps
`default_nettype none
module ssui_list (
   input  wire                    clock,
   input  wire                    reset,
   input  ssui_pkg::list_cmd_type cmd,
   input  ssui_pkg::elem_type     value_in,
   output ssui_pkg::elem_type     head,
   output logic [ssui_pkg::CNT_W-1:0] count,
   output logic                   full
);

   logic [ssui_pkg::CNT_W-1:0] count_ff;
   logic [ssui_pkg::CNT_W-1:0] count_in;
   logic [ssui_pkg::CNT_W-1:0] tail_idx;
   ssui_pkg::elem_type         vals [ssui_pkg::LIST_DEPTH];
   logic                       lts  [ssui_pkg::LIST_DEPTH];
   ssui_pkg::cell_cmd_type     cell_cmd;

   assign count    = count_ff;
   assign full     = (count_ff == ssui_pkg::CNT_W'(ssui_pkg::LIST_DEPTH));
   assign head     = vals[0];
   assign tail_idx = count_ff - ssui_pkg::CNT_W'(1);
   assign cell_cmd.ins   = cmd.ins && !full;
   assign cell_cmd.shift = cmd.shift;

   genvar i;
   generate
      for (i = 0; i < ssui_pkg::LIST_DEPTH; i++) begin : g_cell
         ssui_pkg::elem_type left_v;
         ssui_pkg::elem_type right_v;
         logic               left_l;
         if (i == 0) begin : g_first
            assign left_v = vals[0];
            assign left_l = 1'b1;
         end else begin : g_mid
            assign left_v = vals[i-1];
            assign left_l = lts[i-1];
         end
         if (i == ssui_pkg::LIST_DEPTH - 1) begin : g_last
            assign right_v = vals[0];
         end else begin : g_inner
            assign right_v = (tail_idx == ssui_pkg::CNT_W'(i)) ? vals[0] : vals[i+1];
         end
         ssui_cell u_cell (
            .clock     (clock),
            .cmd       (cell_cmd),
            .value_in  (value_in),
            .left_val  (left_v),
            .right_val (right_v),
            .own_valid (ssui_pkg::CNT_W'(i) < count_ff),
            .left_lt   (left_l),
            .val       (vals[i]),
            .lt        (lts[i])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (cmd.clr) begin
         count_in = '0;
      end else if (cmd.ins && !full) begin
         count_in = count_ff + ssui_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/sorted_set_union_intersection.sv =====
// Sorted set union/intersection top level: two ssui_list chains and the merge sequencer.
// Uses ssui_pkg, ssui_list.
//
// A load item (first or second list) is inserted into its list; busy stays low, so
// loads go back to back. A load to a full list is dropped and sets the sticky overflow
// flag. A compute item raises busy: one pass merges the lists for the union (one
// popped element per cycle, rotated back into its chain), a second pass walks them for
// the intersection. Results come out on rsp_strobe at most one per cycle; each is held
// internally until the next one is found, so the final one can carry last; the receiver
// cannot stall and must take each item in its strobe cycle. With both lists empty, one
// item flagged empty_res is sent the cycle after start. Compute clears both lists and
// the overflow flag.
`timescale 1ns / 1ps
`default_nettype none
module sorted_set_union_intersection (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   output logic              busy,
   input  ssui_pkg::req_type req_item,
   output logic              rsp_strobe,
   output ssui_pkg::rsp_type rsp_item
);

   typedef enum logic [1:0] {ST_IDLE, ST_UNION, ST_INTER} state_type;

   state_type                  state_ff, state_in;
   logic [ssui_pkg::CNT_W-1:0] ra_ff, ra_in, rb_ff, rb_in;
   logic [ssui_pkg::K_W-1:0]   k_ff, k_in;
   ssui_pkg::elem_type         prev_ff, prev_in;
   logic                       have_prev_ff, have_prev_in;
   logic                       pend_valid_ff, pend_valid_in;
   logic                       pend_kind_ff, pend_kind_in;
   ssui_pkg::elem_type         pend_elem_ff, pend_elem_in;
   logic                       dropped_ff, dropped_in;
   logic                       rsp_strobe_ff, rsp_strobe_in;
   ssui_pkg::rsp_type          rsp_ff, rsp_in;

   ssui_pkg::list_cmd_type     cmd_a, cmd_b;
   ssui_pkg::elem_type         head_a, head_b;
   logic [ssui_pkg::CNT_W-1:0] cnt_a, cnt_b;
   logic                       full_a, full_b;
   logic                       accept;
   logic                       room;
   logic                       gen;
   logic                       gen_kind;
   ssui_pkg::elem_type         gen_val;

   ssui_list u_list_a (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd_a),
      .value_in (req_item.value),
      .head     (head_a),
      .count    (cnt_a),
      .full     (full_a)
   );

   ssui_list u_list_b (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd_b),
      .value_in (req_item.value),
      .head     (head_b),
      .count    (cnt_b),
      .full     (full_b)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign room       = (k_ff < ssui_pkg::K_W'(ssui_pkg::MAX_RESULTS));
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      ra_in         = ra_ff;
      rb_in         = rb_ff;
      k_in          = k_ff;
      prev_in       = prev_ff;
      have_prev_in  = have_prev_ff;
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_elem_in  = pend_elem_ff;
      dropped_in    = dropped_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      cmd_a         = '0;
      cmd_b         = '0;
      gen           = 1'b0;
      gen_kind      = ssui_pkg::SET_UNION;
      gen_val       = head_a;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_item.action)
                  ssui_pkg::ACT_FIRST: begin
                     cmd_a.ins = 1'b1;
                     if (full_a) dropped_in = 1'b1;
                  end
                  ssui_pkg::ACT_SECOND: begin
                     cmd_b.ins = 1'b1;
                     if (full_b) dropped_in = 1'b1;
                  end
                  ssui_pkg::ACT_COMPUTE: begin
                     if (cnt_a == '0 && cnt_b == '0) begin
                        rsp_strobe_in      = 1'b1;
                        rsp_in.set_kind    = ssui_pkg::SET_UNION;
                        rsp_in.element     = '0;
                        rsp_in.empty_res   = 1'b1;
                        rsp_in.overflow    = dropped_ff;
                        rsp_in.last        = 1'b1;
                        dropped_in         = 1'b0;
                     end else begin
                        state_in      = ST_UNION;
                        ra_in         = cnt_a;
                        rb_in         = cnt_b;
                        k_in          = '0;
                        have_prev_in  = 1'b0;
                        pend_valid_in = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_UNION: begin
            if ((ra_ff != '0 || rb_ff != '0) && room) begin
               if (rb_ff == '0 || (ra_ff != '0 && !(head_b < head_a))) begin
                  cmd_a.shift = 1'b1;
                  ra_in       = ra_ff - ssui_pkg::CNT_W'(1);
                  gen_val     = head_a;
               end else begin
                  cmd_b.shift = 1'b1;
                  rb_in       = rb_ff - ssui_pkg::CNT_W'(1);
                  gen_val     = head_b;
               end
               gen = !have_prev_ff || (gen_val != prev_ff);
            end else begin
               state_in     = ST_INTER;
               ra_in        = cnt_a;
               rb_in        = cnt_b;
               have_prev_in = 1'b0;
            end
         end
         ST_INTER: begin
            if (ra_ff != '0 && rb_ff != '0 && room) begin
               if (head_a < head_b) begin
                  cmd_a.shift = 1'b1;
                  ra_in       = ra_ff - ssui_pkg::CNT_W'(1);
               end else if (head_b < head_a) begin
                  cmd_b.shift = 1'b1;
                  rb_in       = rb_ff - ssui_pkg::CNT_W'(1);
               end else begin
                  cmd_a.shift = 1'b1;
                  cmd_b.shift = 1'b1;
                  ra_in       = ra_ff - ssui_pkg::CNT_W'(1);
                  rb_in       = rb_ff - ssui_pkg::CNT_W'(1);
                  gen_kind    = ssui_pkg::SET_INTER;
                  gen_val     = head_a;
                  gen         = !have_prev_ff || (head_a != prev_ff);
               end
            end else begin
               rsp_strobe_in    = 1'b1;
               rsp_in.set_kind  = pend_kind_ff;
               rsp_in.element   = pend_elem_ff;
               rsp_in.empty_res = 1'b0;
               rsp_in.overflow  = dropped_ff;
               rsp_in.last      = 1'b1;
               pend_valid_in    = 1'b0;
               cmd_a.clr        = 1'b1;
               cmd_b.clr        = 1'b1;
               dropped_in       = 1'b0;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // new distinct result: release the held one, hold this one
      if (gen) begin
         prev_in       = gen_val;
         have_prev_in  = 1'b1;
         k_in          = k_ff + ssui_pkg::K_W'(1);
         pend_valid_in = 1'b1;
         pend_kind_in  = gen_kind;
         pend_elem_in  = gen_val;
         if (pend_valid_ff) begin
            rsp_strobe_in    = 1'b1;
            rsp_in.set_kind  = pend_kind_ff;
            rsp_in.element   = pend_elem_ff;
            rsp_in.empty_res = 1'b0;
            rsp_in.overflow  = dropped_ff;
            rsp_in.last      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         dropped_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         have_prev_ff  <= 1'b0;
         ra_ff         <= '0;
         rb_ff         <= '0;
         k_ff          <= '0;
      end else begin
         state_ff      <= state_in;
         dropped_ff    <= dropped_in;
         rsp_strobe_ff <= rsp_strobe_in;
         pend_valid_ff <= pend_valid_in;
         have_prev_ff  <= have_prev_in;
         ra_ff         <= ra_in;
         rb_ff         <= rb_in;
         k_ff          <= k_in;
      end
      prev_ff      <= prev_in;
      pend_kind_ff <= pend_kind_in;
      pend_elem_ff <= pend_elem_in;
      rsp_ff       <= rsp_in;
   end

endmodule
`default_nettype wire
